// File: hdl/frs_pkg.sv
// shared types, constants and helpers of the flat triangle span rasterizer
`default_nettype none
package frs_pkg;

  localparam int SCREEN_WIDTH   = 160;
  localparam int SCREEN_HEIGHT  = 128;
  localparam int EDGE_FRAC_BITS = 4;

  localparam int PIX_W  = 13;
  localparam int DVD_W  = PIX_W + 1 + EDGE_FRAC_BITS;
  localparam int STEP_W = 20;
  localparam int EDGE_W = 24;

  typedef logic signed [PIX_W-1:0]  pix_t;
  typedef logic signed [DVD_W-1:0]  dvd_t;
  typedef logic [PIX_W-1:0]         dvs_t;
  typedef logic signed [STEP_W-1:0] step_t;
  typedef logic signed [EDGE_W-1:0] edge_t;

  typedef enum logic [1:0] {
    REQ_SUBMIT = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic {
    CFG_TARGET_ENABLED = 1'b0,
    CFG_BUFFER_BASE    = 1'b1
  } cfg_e;

  typedef enum logic [1:0] {
    DIV_SEL_LONG  = 2'd0,
    DIV_SEL_SHORT = 2'd1,
    DIV_SEL_HALF  = 2'd2,
    DIV_SEL_NONE  = 2'd3
  } div_sel_e;

  typedef struct packed {
    logic     accept_submit;
    logic     accept_tick;
    logic     accept_clear;
    logic     setup;
    logic     div_start;
    div_sel_e div_sel;
    logic     commit_long;
    logic     commit_short;
    logic     commit_half;
  } frs_cmd_t;

  typedef struct packed {
    logic enabled;
    logic reject;
    logic need_half;
    logic div_done;
    logic out_full;
  } frs_stat_t;

  function automatic pix_t to_pixel(input logic signed [19:0] v);
    logic signed [20:0] s;
    s = {v[19], v} + 21'sd128;
    return s[20:8];
  endfunction

endpackage
`default_nettype wire

// File: hdl/frs_div.sv
// iterative signed by positive divider, quotient truncated toward zero
`default_nettype none
module frs_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  frs_pkg::dvd_t       dividend_i,
  input  frs_pkg::dvs_t       divisor_i,
  output logic                done_o,
  output frs_pkg::step_t      quotient_o
);
  import frs_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DVD_W-1:0]   quo_q, quo_d;
  logic [PIX_W-1:0]   rem_q, rem_d;
  logic [PIX_W-1:0]   dvs_q, dvs_d;
  logic               neg_q, neg_d;
  logic [PIX_W:0]     rem_sh;
  logic [PIX_W:0]     diff;
  logic               fits;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[DVD_W-1];
      quo_d  = dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
    end else if (busy_q) begin
      rem_d = fits ? diff[PIX_W-1:0] : rem_sh[PIX_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -step_t'({2'b00, quo_q}) : step_t'({2'b00, quo_q});

endmodule
`default_nettype wire

// File: hdl/frs_dp.sv
// datapath: setup, edge walk state, span clipping, output register
`default_nettype none
module frs_dp (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire                   cfg_index_i,
  input  wire  [23:0]           cfg_data_i,
  input  frs_pkg::frs_cmd_t     cmd_i,
  output frs_pkg::frs_stat_t    stat_o,
  input  wire  signed [19:0]    v0_x_i,
  input  wire  signed [19:0]    v0_y_i,
  input  wire  signed [19:0]    v1_x_i,
  input  wire  signed [19:0]    v1_y_i,
  input  wire  signed [19:0]    v2_x_i,
  input  wire  signed [19:0]    v2_y_i,
  input  wire  [15:0]           fill_color_i,
  input  wire                   out_take_i,
  output logic                  span_valid_o,
  output logic [6:0]            span_row_o,
  output logic [7:0]            span_x_start_o,
  output logic [7:0]            span_x_end_o,
  output logic [23:0]           span_addr_o,
  output logic [15:0]           span_color_o,
  output logic                  last_row_o,
  output logic [31:0]           triangle_count_o
);
  import frs_pkg::*;

  logic        en_q;
  logic [23:0] base_q;

  pix_t        px_q [3];
  pix_t        py_q [3];
  logic [15:0] col_stage_q;
  pix_t        ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  step_t       lstep_stage_q;

  logic        busy_q, second_q;
  pix_t        scan_q, half_end_q;
  edge_t       lx_q, sx_q;
  step_t       lstep_q, sstep_q;
  pix_t        mid_x_q, bot_x_q, bot_y_q;
  logic [15:0] color_q;
  logic [31:0] count_q;

  logic        ov_q;
  logic        o_vis_q, o_last_q;
  logic [6:0]  o_row_q;
  logic [7:0]  o_x0_q, o_x1_q;
  logic [23:0] o_addr_q;
  logic [15:0] o_col_q;
  logic [31:0] o_cnt_q;

  // sort and bounding box
  pix_t sa_x, sa_y, sb_x, sb_y, sc_x, sc_y;
  pix_t min_x, max_x, min_y, max_y;
  logic reject;

  always_comb begin
    if (py_q[0] <= py_q[1] && py_q[0] <= py_q[2]) begin
      sa_x = px_q[0]; sa_y = py_q[0]; sb_x = px_q[1]; sb_y = py_q[1];
      sc_x = px_q[2]; sc_y = py_q[2];
    end else if (py_q[1] <= py_q[0] && py_q[1] <= py_q[2]) begin
      sa_x = px_q[1]; sa_y = py_q[1]; sb_x = px_q[0]; sb_y = py_q[0];
      sc_x = px_q[2]; sc_y = py_q[2];
    end else begin
      sa_x = px_q[2]; sa_y = py_q[2]; sb_x = px_q[0]; sb_y = py_q[0];
      sc_x = px_q[1]; sc_y = py_q[1];
    end
    if (sb_y > sc_y) begin
      {sb_x, sc_x} = {sc_x, sb_x};
      {sb_y, sc_y} = {sc_y, sb_y};
    end
    min_x = px_q[0]; max_x = px_q[0]; min_y = py_q[0]; max_y = py_q[0];
    for (int i = 1; i < 3; i++) begin
      if (px_q[i] < min_x) min_x = px_q[i];
      if (px_q[i] > max_x) max_x = px_q[i];
      if (py_q[i] < min_y) min_y = py_q[i];
      if (py_q[i] > max_y) max_y = py_q[i];
    end
    reject = (max_y < 0) || (min_y >= pix_t'(SCREEN_HEIGHT)) || (max_x < 0) ||
             (min_x >= pix_t'(SCREEN_WIDTH)) || (sc_y <= sa_y);
  end

  // divider operands
  logic signed [PIX_W:0] dx, dh;
  dvd_t  div_dvd;
  dvs_t  div_dvs;
  logic  div_done;
  step_t div_q;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_SEL_LONG: begin
        dx = {sc_x[PIX_W-1], sc_x} - {sa_x[PIX_W-1], sa_x};
        dh = {sc_y[PIX_W-1], sc_y} - {sa_y[PIX_W-1], sa_y};
      end
      DIV_SEL_SHORT: begin
        if (by_q > ay_q) begin
          dx = {bx_q[PIX_W-1], bx_q} - {ax_q[PIX_W-1], ax_q};
          dh = {by_q[PIX_W-1], by_q} - {ay_q[PIX_W-1], ay_q};
        end else begin
          dx = {cx_q[PIX_W-1], cx_q} - {bx_q[PIX_W-1], bx_q};
          dh = {cy_q[PIX_W-1], cy_q} - {by_q[PIX_W-1], by_q};
        end
      end
      DIV_SEL_HALF: begin
        dx = {bot_x_q[PIX_W-1], bot_x_q} - {mid_x_q[PIX_W-1], mid_x_q};
        dh = {bot_y_q[PIX_W-1], bot_y_q} - {half_end_q[PIX_W-1], half_end_q};
      end
      default: begin
        dx = '0;
        dh = '0;
      end
    endcase
    div_dvd = {dx, {EDGE_FRAC_BITS{1'b0}}};
    div_dvs = dh[PIX_W-1:0];
  end

  frs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // one row of the walk
  localparam int XW = EDGE_W - EDGE_FRAC_BITS;
  logic signed [XW-1:0] xl, xr, lo, hi, x0, x1;
  logic        row_ok, vis;
  pix_t        scan_n;
  edge_t       lx_n, sx_n;
  logic        finish, need_half;
  logic [23:0] addr;

  always_comb begin
    xl = lx_q[EDGE_W-1:EDGE_FRAC_BITS];
    xr = sx_q[EDGE_W-1:EDGE_FRAC_BITS];
    lo = (xl > xr) ? xr : xl;
    hi = (xl > xr) ? xl : xr;
    row_ok = (scan_q >= 0) && (scan_q < pix_t'(SCREEN_HEIGHT));
    x0 = (lo < 0) ? '0 : lo;
    x1 = (hi > XW'(SCREEN_WIDTH - 1)) ? XW'(SCREEN_WIDTH - 1) : hi;
    vis = row_ok && (x0 <= x1);
    addr = base_q + 24'(scan_q[6:0]) * 24'(SCREEN_WIDTH) + 24'(x0[7:0]);
    scan_n = scan_q + 1'b1;
    lx_n = lx_q + edge_t'(lstep_q);
    sx_n = sx_q + edge_t'(sstep_q);
    finish = 1'b0;
    need_half = 1'b0;
    if (!second_q) begin
      if (scan_n >= half_end_q) begin
        if (bot_y_q > half_end_q) need_half = 1'b1;
        else finish = 1'b1;
      end
    end else if (scan_n > half_end_q) begin
      finish = 1'b1;
    end
    if (!busy_q) begin
      finish = 1'b0;
      need_half = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      base_q   <= '0;
      busy_q   <= 1'b0;
      second_q <= 1'b0;
      count_q  <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_TARGET_ENABLED: en_q   <= cfg_data_i[0];
          CFG_BUFFER_BASE:    base_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept_clear) count_q <= '0;
      else if (cmd_i.accept_submit && en_q) count_q <= count_q + 1'b1;
      if (cmd_i.commit_short) begin
        busy_q   <= 1'b1;
        second_q <= !(by_q > ay_q);
      end else if (cmd_i.commit_half) begin
        second_q <= 1'b1;
      end else if (cmd_i.accept_tick && finish) begin
        busy_q   <= 1'b0;
        second_q <= 1'b0;
      end
      if (cmd_i.accept_tick) ov_q <= 1'b1;
      else if (out_take_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_submit) begin
      px_q[0] <= to_pixel(v0_x_i); py_q[0] <= to_pixel(v0_y_i);
      px_q[1] <= to_pixel(v1_x_i); py_q[1] <= to_pixel(v1_y_i);
      px_q[2] <= to_pixel(v2_x_i); py_q[2] <= to_pixel(v2_y_i);
      col_stage_q <= fill_color_i;
    end
    if (cmd_i.setup) begin
      ax_q <= sa_x; ay_q <= sa_y; bx_q <= sb_x; by_q <= sb_y;
      cx_q <= sc_x; cy_q <= sc_y;
    end
    if (cmd_i.commit_long) lstep_stage_q <= div_q;
    if (cmd_i.commit_short) begin
      color_q <= col_stage_q;
      mid_x_q <= bx_q;
      bot_x_q <= cx_q;
      bot_y_q <= cy_q;
      lx_q    <= edge_t'(ax_q) <<< EDGE_FRAC_BITS;
      lstep_q <= lstep_stage_q;
      sstep_q <= div_q;
      if (by_q > ay_q) begin
        scan_q     <= ay_q;
        half_end_q <= by_q;
        sx_q       <= edge_t'(ax_q) <<< EDGE_FRAC_BITS;
      end else begin
        scan_q     <= by_q;
        half_end_q <= cy_q;
        sx_q       <= edge_t'(bx_q) <<< EDGE_FRAC_BITS;
      end
    end else if (cmd_i.commit_half) begin
      sx_q       <= edge_t'(mid_x_q) <<< EDGE_FRAC_BITS;
      sstep_q    <= div_q;
      half_end_q <= bot_y_q;
    end else if (cmd_i.accept_tick && busy_q) begin
      lx_q   <= lx_n;
      sx_q   <= sx_n;
      scan_q <= scan_n;
    end
    if (cmd_i.accept_tick) begin
      o_vis_q  <= busy_q && vis;
      o_row_q  <= (busy_q && vis) ? scan_q[6:0] : '0;
      o_x0_q   <= (busy_q && vis) ? x0[7:0] : '0;
      o_x1_q   <= (busy_q && vis) ? x1[7:0] : '0;
      o_addr_q <= (busy_q && vis) ? addr : '0;
      o_col_q  <= (busy_q && vis) ? color_q : '0;
      o_last_q <= finish;
      o_cnt_q  <= count_q;
    end
  end

  assign stat_o.enabled   = en_q;
  assign stat_o.reject    = reject;
  assign stat_o.need_half = need_half;
  assign stat_o.div_done  = div_done;
  assign stat_o.out_full  = ov_q;

  assign span_valid_o     = o_vis_q;
  assign span_row_o       = o_row_q;
  assign span_x_start_o   = o_x0_q;
  assign span_x_end_o     = o_x1_q;
  assign span_addr_o      = o_addr_q;
  assign span_color_o     = o_col_q;
  assign last_row_o       = o_last_q;
  assign triangle_count_o = o_cnt_q;

endmodule
`default_nettype wire

// File: hdl/frs_ctrl.sv
// controller state machine: request decode, setup sequence, half switch
`default_nettype none
module frs_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [1:0]          req_type_i,
  input  wire                 out_stall_i,
  output logic                out_take_o,
  input  wire                 out_valid_i,
  input  frs_pkg::frs_stat_t  stat_i,
  output frs_pkg::frs_cmd_t   cmd_o
);
  import frs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_SETUP     = 5'b00010,
    S_DIV_LONG  = 5'b00100,
    S_DIV_SHORT = 5'b01000,
    S_DIV_HALF  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign out_take_o = out_valid_i && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || (stat_i.out_full && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{div_sel: DIV_SEL_NONE, default: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_e'(req_type_i))
            REQ_SUBMIT: begin
              cmd_o.accept_submit = 1'b1;
              if (stat_i.enabled) state_d = S_SETUP;
            end
            REQ_TICK: begin
              cmd_o.accept_tick = 1'b1;
              if (stat_i.need_half) begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_sel   = DIV_SEL_HALF;
                state_d         = S_DIV_HALF;
              end
            end
            REQ_CLEAR: cmd_o.accept_clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        if (stat_i.reject) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_SEL_LONG;
          state_d         = S_DIV_LONG;
        end
      end
      S_DIV_LONG: begin
        if (stat_i.div_done) begin
          cmd_o.commit_long = 1'b1;
          cmd_o.div_start   = 1'b1;
          cmd_o.div_sel     = DIV_SEL_SHORT;
          state_d           = S_DIV_SHORT;
        end
      end
      S_DIV_SHORT: begin
        if (stat_i.div_done) begin
          cmd_o.commit_short = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_DIV_HALF: begin
        cmd_o.div_sel = DIV_SEL_HALF;
        if (stat_i.div_done) begin
          cmd_o.commit_half = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_stall_when_working: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("item taken while working");

  a_div_start_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == S_DIV_LONG || state_q == S_DIV_SHORT ||
                         state_q == S_DIV_HALF)) else $error("divide not awaited");

  a_no_stray_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat_i.div_done && state_q == S_IDLE)) else $error("divide done while idle");

endmodule
`default_nettype wire

// File: hdl/flat_triangle_span_rasterizer_top.sv
// a tick places its span in the output register in the cycle after acceptance
// a tick that starts the lower half holds off new items until its divide finishes
// an enabled submit runs setup and, unless rejected, two passes of the serial divider
// the divider retires one quotient bit per cycle over 18 bits
// reset: asynchronous active low, clears configuration, walk control and the counter
`default_nettype none
module flat_triangle_span_rasterizer_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire                cfg_index_i,
  input  wire  [23:0]        cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [1:0]         req_type_i,
  input  wire  signed [19:0] v0_x_i,
  input  wire  signed [19:0] v0_y_i,
  input  wire  signed [19:0] v1_x_i,
  input  wire  signed [19:0] v1_y_i,
  input  wire  signed [19:0] v2_x_i,
  input  wire  signed [19:0] v2_y_i,
  input  wire  [15:0]        fill_color_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic               span_valid_o,
  output logic [6:0]         span_row_o,
  output logic [7:0]         span_x_start_o,
  output logic [7:0]         span_x_end_o,
  output logic [23:0]        span_addr_o,
  output logic [15:0]        span_color_o,
  output logic               last_row_o,
  output logic [31:0]        triangle_count_o
);
  import frs_pkg::*;

  frs_cmd_t  cmd;
  frs_stat_t stat;
  logic      out_take;

  assign out_valid_o = stat.out_full;

  frs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_stall_i (out_stall_i),
    .out_take_o  (out_take),
    .out_valid_i (stat.out_full),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  frs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .v0_x_i           (v0_x_i),
    .v0_y_i           (v0_y_i),
    .v1_x_i           (v1_x_i),
    .v1_y_i           (v1_y_i),
    .v2_x_i           (v2_x_i),
    .v2_y_i           (v2_y_i),
    .fill_color_i     (fill_color_i),
    .out_take_i       (out_take),
    .span_valid_o     (span_valid_o),
    .span_row_o       (span_row_o),
    .span_x_start_o   (span_x_start_o),
    .span_x_end_o     (span_x_end_o),
    .span_addr_o      (span_addr_o),
    .span_color_o     (span_color_o),
    .last_row_o       (last_row_o),
    .triangle_count_o (triangle_count_o)
  );

endmodule
`default_nettype wire
